[design/prm_pkg.sv]
`default_nettype none
package prm_pkg;

   localparam int TS_W       = 32;
   localparam int SIZE_W     = 16;
   localparam int RATE_W     = 32;
   localparam int GRAN_W     = 20;
   localparam int WEIGHT_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // size * scale, and the weighted sum before the divide by one hundred
   localparam int DIVIDEND_W = SIZE_W + GRAN_W;
   localparam int SUM_W      = RATE_W + WEIGHT_W;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = RATE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // divide by one hundred: sum = hi * 2^32 + lo, 2^32 = 100 * HI_QUOTIENT + HI_REMAINDER,
   // then (hi * HI_REMAINDER + lo) / 4 / 25 by reciprocal multiply
   localparam int RECIP_W     = RATE_W - 1;
   localparam int PROD_W      = 2 * RECIP_W;
   localparam int RECIP_SHIFT = 35;

   localparam logic [GRAN_W-1:0]   RATE_SCALE    = 20'd1000000;
   localparam logic [WEIGHT_W-1:0] PERCENT_FULL  = 7'd100;
   localparam logic [GRAN_W-1:0]   GRAN_RESET    = 20'd1000000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 7'd50;
   localparam logic [RATE_W-1:0]   HI_QUOTIENT   = 32'd42949672;
   localparam logic [WEIGHT_W-1:0] HI_REMAINDER  = 7'd96;
   localparam logic [RECIP_W-1:0]  RECIP_MUL     = 31'd1374389535;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_GRANULARITY = 2'd1,
      CSR_WEIGHT      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TS_W-1:0]   timestamp_us;
      logic [SIZE_W-1:0] packet_size;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] average_rate;
      logic [RATE_W-1:0] peak_rate;
      logic [RATE_W-1:0] packet_count;
      logic [RATE_W-1:0] byte_count;
      logic [TS_W-1:0]   elapsed_us;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RLOAD,
      ST_RDIV,
      ST_RATE,
      ST_BMUL1,
      ST_BMUL2,
      ST_BLOAD,
      ST_BRECIP,
      ST_BSUM,
      ST_AVG,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic calc_mul;
      logic div_load_rate;
      logic div_step;
      logic take_rate;
      logic mul_first;
      logic mul_second;
      logic recip_load;
      logic recip_mul;
      logic recip_sum;
      logic update_avg;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic started;
      logic gap_ok;
      logic avg_zero;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

[design/prm_ctrl.sv]
`default_nettype none
module prm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire prm_pkg::status_type status,
   output prm_pkg::cmd_type        cmd
);
   import prm_pkg::*;

   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.enable && status.started && status.gap_ok) begin
               cmd.calc_mul = 1'b1;
               state_in     = ST_RLOAD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_RLOAD: begin
            cmd.div_load_rate = 1'b1;
            cnt_in            = '0;
            state_in          = ST_RDIV;
         end
         ST_RDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) state_in = ST_RATE;
         end
         ST_RATE: begin
            cmd.take_rate = 1'b1;
            state_in      = status.avg_zero ? ST_AVG : ST_BMUL1;
         end
         ST_BMUL1: begin
            cmd.mul_first = 1'b1;
            state_in      = ST_BMUL2;
         end
         ST_BMUL2: begin
            cmd.mul_second = 1'b1;
            state_in       = ST_BLOAD;
         end
         ST_BLOAD: begin
            cmd.recip_load = 1'b1;
            state_in       = ST_BRECIP;
         end
         ST_BRECIP: begin
            cmd.recip_mul = 1'b1;
            state_in      = ST_BSUM;
         end
         ST_BSUM: begin
            cmd.recip_sum = 1'b1;
            state_in      = ST_AVG;
         end
         ST_AVG: begin
            cmd.update_avg = 1'b1;
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.commit   = status.enable;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_CHECK))
      else $error("accepted beat did not start a check");

   a_rate_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDIV && cnt_ff == STEP_LAST) |=> (state_ff == ST_RATE))
      else $error("rate divide did not end after its last step");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RLOAD) |=> (cnt_ff == '0))
      else $error("divide step count not cleared at load");

endmodule
`default_nettype wire

[design/prm_datapath.sv]
`default_nettype none
module prm_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [prm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [prm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire prm_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output prm_pkg::rsp_type                       rsp_data,
   input  wire prm_pkg::cmd_type                  cmd,
   output prm_pkg::status_type                    status
);
   import prm_pkg::*;

   // configuration
   logic                enable_ff;
   logic [GRAN_W-1:0]   gran_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   // meter state
   logic              started_ff, started_in;
   logic [TS_W-1:0]   first_ff, first_in;
   logic [TS_W-1:0]   last_ff, last_in;
   logic [RATE_W-1:0] smoothed_ff, smoothed_in;
   logic [RATE_W-1:0] highest_ff, highest_in;
   logic [RATE_W-1:0] packets_ff, packets_in;
   logic [RATE_W-1:0] bytes_ff, bytes_in;

   // work registers
   req_type               in_ff;
   logic [DIVIDEND_W-1:0] dividend_ff;
   logic [GRAN_W-1:0]     gap_ff;
   logic                  ovf_ff;
   logic [GRAN_W-1:0]     rem_ff;
   logic [RATE_W-1:0]     quo_ff;
   logic [GRAN_W-1:0]     div_ff;
   logic [RATE_W-1:0]     inst_ff;
   logic [SUM_W-1:0]      p1_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [RECIP_W-1:0]    recip_x_ff;
   logic [RATE_W-1:0]     hi_quo_ff;
   logic [PROD_W-1:0]     prod_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [TS_W-1:0]     gap;
   logic [WEIGHT_W-1:0] weight_sat;
   logic [WEIGHT_W-1:0] weight_inv;
   logic [GRAN_W:0]     trial;
   logic [GRAN_W:0]     trial_diff;
   logic                trial_fits;
   logic [WEIGHT_W-1:0] sum_hi;
   logic [RATE_W:0]     fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         gran_ff   <= GRAN_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:      enable_ff <= csr_write_data[0];
            CSR_GRANULARITY: gran_ff   <= csr_write_data[GRAN_W-1:0];
            CSR_WEIGHT:      weight_ff <= csr_write_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign gap        = in_ff.timestamp_us - last_ff;
   assign weight_sat = (weight_ff > PERCENT_FULL) ? PERCENT_FULL : weight_ff;
   assign weight_inv = PERCENT_FULL - weight_sat;

   // restoring divide step, remainder below divisor unless the quotient overflows
   assign trial      = {rem_ff, quo_ff[RATE_W-1]};
   assign trial_fits = (trial >= {1'b0, div_ff});
   assign trial_diff = trial - {1'b0, div_ff};

   // upper sum bits are below one hundred, fold their remainder into the low word
   assign sum_hi = sum_ff[SUM_W-1:RATE_W];
   assign fold   = {1'b0, sum_ff[RATE_W-1:0]}
                 + (RATE_W+1)'(sum_hi) * (RATE_W+1)'(HI_REMAINDER);

   always_comb begin
      started_in  = started_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      smoothed_in = smoothed_ff;
      highest_in  = highest_ff;
      packets_in  = packets_ff;
      bytes_in    = bytes_ff;
      if (cmd.update_avg) begin
         smoothed_in = (smoothed_ff == '0) ? inst_ff : quo_ff;
         if (smoothed_in > highest_ff) highest_in = smoothed_in;
      end
      if (cmd.commit) begin
         packets_in = packets_ff + 1'b1;
         bytes_in   = bytes_ff + RATE_W'(in_ff.packet_size);
         last_in    = in_ff.timestamp_us;
         if (!started_ff) begin
            started_in = 1'b1;
            first_in   = in_ff.timestamp_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         smoothed_ff  <= '0;
         highest_ff   <= '0;
         packets_ff   <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff  <= started_in;
         first_ff    <= first_in;
         last_ff     <= last_in;
         smoothed_ff <= smoothed_in;
         highest_ff  <= highest_in;
         packets_ff  <= packets_in;
         bytes_ff    <= bytes_in;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) in_ff <= req_data;
      if (cmd.calc_mul) begin
         dividend_ff <= DIVIDEND_W'(in_ff.packet_size) * DIVIDEND_W'(RATE_SCALE);
         gap_ff      <= gap[GRAN_W-1:0];
      end
      if (cmd.div_load_rate) begin
         // quotient would not fit 32 bits, also covers a zero gap
         ovf_ff <= (GRAN_W'(dividend_ff[DIVIDEND_W-1:RATE_W]) >= gap_ff);
         rem_ff <= GRAN_W'(dividend_ff[DIVIDEND_W-1:RATE_W]);
         quo_ff <= dividend_ff[RATE_W-1:0];
         div_ff <= gap_ff;
      end else if (cmd.div_step) begin
         rem_ff <= trial_fits ? trial_diff[GRAN_W-1:0] : trial[GRAN_W-1:0];
         quo_ff <= {quo_ff[RATE_W-2:0], trial_fits};
      end else if (cmd.recip_sum) begin
         quo_ff <= hi_quo_ff + RATE_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
      end
      if (cmd.take_rate) inst_ff <= ovf_ff ? '1 : quo_ff;
      if (cmd.mul_first) p1_ff <= SUM_W'(smoothed_ff) * SUM_W'(weight_inv);
      if (cmd.mul_second) sum_ff <= p1_ff + SUM_W'(inst_ff) * SUM_W'(weight_sat);
      // divide by four here, by twenty-five in the reciprocal multiply
      if (cmd.recip_load) begin
         recip_x_ff <= fold[RATE_W:2];
         hi_quo_ff  <= RATE_W'(sum_hi) * HI_QUOTIENT;
      end
      if (cmd.recip_mul) prod_ff <= PROD_W'(recip_x_ff) * PROD_W'(RECIP_MUL);
      if (cmd.load_rsp) begin
         rsp_ff.average_rate <= smoothed_in;
         rsp_ff.peak_rate    <= highest_in;
         rsp_ff.packet_count <= packets_in;
         rsp_ff.byte_count   <= bytes_in;
         rsp_ff.elapsed_us   <= last_in - first_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.enable   = enable_ff;
   assign status.started  = started_ff;
   assign status.gap_ok   = (gap < TS_W'(gran_ff));
   assign status.avg_zero = (smoothed_ff == '0);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      highest_ff >= smoothed_ff)
      else $error("peak below smoothed rate");

   a_unstarted_empty: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (packets_ff == '0 && bytes_ff == '0 && smoothed_ff == '0))
      else $error("counts moved before the first packet");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an untaken beat");

endmodule
`default_nettype wire

[design/packet_rate_meter_top.sv]
`default_nettype none
// packet rate meter: each accepted req beat is one packet (microsecond timestamp
// and byte size) and yields exactly one rsp beat with the smoothed rate, its
// peak, wrapping packet and byte counts, and the time since the first packet.
// the first enabled packet only marks the start time; later packets whose gap
// is below granularity_us form an instant rate size*1e6/gap (saturating at
// 2^32-1, also for a zero gap) that seeds or is blended into a percent-weighted
// average. with enable low nothing changes and the current state is reported.
// a packet that forms no rate goes from the check straight to write back; one
// that seeds the average also runs the divider, one that blends also the blend
// multiplies and the reciprocal scale; write back waits while the previous rsp
// beat is still stalled. the instant rate comes from a 32-step restoring
// divider; the divide by one hundred of the blend is a reciprocal multiply
// spread over a load, a multiply and a sum state. a new req beat is taken once
// the previous one has reached the output register, even while that rsp beat
// still waits. csr writes are taken at any edge and belong in idle periods.
module packet_rate_meter_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_write_enable,
   input  wire logic [prm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [prm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // packet events
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire prm_pkg::req_type                req_data,
   // meter results
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output prm_pkg::rsp_type                     rsp_data
);
   import prm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: check, rate divide, blend, reciprocal scale, write back
   prm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // csr, meter state, rate divider, multipliers and output register
   prm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import prm_pkg::*;

   // a packet, even one that blends its rate, is short next to these limits,
   // so long quiet stretches only happen during the long rsp hold-off
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned SETTLE_CYCLES  = 80;

   localparam logic [63:0]         USEC_PER_SEC = 64'd1000000;
   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT  = 7'd100;
   localparam logic [GRAN_W-1:0]   GRAN_MAX     = 20'hFFFFF;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;

   packet_rate_meter_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   // predicted register settings, tracking every csr write
   logic                meter_on;
   logic [GRAN_W-1:0]   meter_gran;
   logic [WEIGHT_W-1:0] meter_weight;

   // predicted meter state
   logic                meter_started;
   logic [TS_W-1:0]     meter_first;
   logic [TS_W-1:0]     meter_last;
   logic [RATE_W-1:0]   meter_avg;
   logic [RATE_W-1:0]   meter_peak;
   logic [RATE_W-1:0]   meter_packets;
   logic [RATE_W-1:0]   meter_bytes;

   // meter readings still owed by the block, oldest first
   rsp_type         owed_readings[$];
   int unsigned     mismatches;

   // stimulus knobs
   logic [TS_W-1:0] tx_clock;      // timestamp cursor of the packet source
   logic            tx_quiet;      // no gaps between req beats
   logic            rx_quiet;      // no random rsp stalls
   logic            hold_request;  // ask the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // bytes per second over the gap, saturating at all ones
   function automatic logic [RATE_W-1:0] instant_rate_of(input logic [SIZE_W-1:0] size,
                                                         input logic [TS_W-1:0] gap);
      logic [63:0] quotient;
      if (gap == '0)
         return '1;
      quotient = (64'(size) * USEC_PER_SEC) / 64'(gap);
      if (quotient > 64'h0000_0000_FFFF_FFFF)
         return '1;
      return quotient[RATE_W-1:0];
   endfunction

   // percent-weighted average, weights above one hundred act as one hundred
   function automatic logic [RATE_W-1:0] blended_rate(input logic [RATE_W-1:0] avg,
                                                      input logic [RATE_W-1:0] inst);
      logic [63:0] w;
      logic [63:0] sum;
      logic [63:0] quotient;
      w = (meter_weight > FULL_WEIGHT) ? 64'(FULL_WEIGHT) : 64'(meter_weight);
      sum = 64'(avg) * (64'(FULL_WEIGHT) - w) + 64'(inst) * w;
      quotient = sum / 64'(FULL_WEIGHT);
      return quotient[RATE_W-1:0];
   endfunction

   // advance the predicted meter by one packet and return its reading
   function automatic rsp_type predict_packet(input req_type pkt);
      rsp_type          reading;
      logic [TS_W-1:0]  gap;
      logic [RATE_W-1:0] inst;
      if (meter_on) begin
         if (!meter_started) begin
            // first packet only marks the start time
            meter_started = 1'b1;
            meter_first   = pkt.timestamp_us;
         end else begin
            gap = pkt.timestamp_us - meter_last;
            if (gap < TS_W'(meter_gran)) begin
               inst = instant_rate_of(pkt.packet_size, gap);
               meter_avg = (meter_avg == '0) ? inst : blended_rate(meter_avg, inst);
               if (meter_avg > meter_peak)
                  meter_peak = meter_avg;
            end
         end
         meter_packets = meter_packets + 1;
         meter_bytes   = meter_bytes + RATE_W'(pkt.packet_size);
         meter_last    = pkt.timestamp_us;
      end
      reading.average_rate = meter_avg;
      reading.peak_rate    = meter_peak;
      reading.packet_count = meter_packets;
      reading.byte_count   = meter_bytes;
      reading.elapsed_us   = meter_last - meter_first;
      return reading;
   endfunction

   // ---------------------------------------------------------------------
   // random shapes
   // ---------------------------------------------------------------------

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(15, 4);
      return $urandom_range(200, 40);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15)
         return '1;
      if (r < 25)
         return '0;
      if (r < 35)
         return SIZE_W'($urandom_range(64, 1));
      return SIZE_W'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // drivers: inputs move on the falling edge, beats count on the rising edge
   // ---------------------------------------------------------------------

   // offer one packet beat, wait for it to be taken, then idle a while
   task automatic send_packet(input logic [TS_W-1:0] ts, input logic [SIZE_W-1:0] size);
      req_type     pkt;
      int unsigned gap;
      pkt.timestamp_us = ts;
      pkt.packet_size  = size;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= pkt;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owed_readings.push_back(predict_packet(pkt));
      gap = tx_quiet ? 0 : pick_gap();
      // with no gap valid stays high and the next call just swaps the data
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // next packet a given number of microseconds after the last one
   task automatic send_after(input logic [TS_W-1:0] step, input logic [SIZE_W-1:0] size);
      tx_clock = tx_clock + step;
      send_packet(tx_clock, size);
   endtask

   // stop offering and wait until every owed reading has come back
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_readings.size() != 0)
         @(posedge clock);
      // every packet yields a reading, so a short settle is enough
      repeat (4) @(posedge clock);
   endtask

   // register write, always from an idle block
   task automatic csr_set(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      wait_drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_ENABLE:      meter_on     = value[0];
         CSR_GRANULARITY: meter_gran   = value[GRAN_W-1:0];
         CSR_WEIGHT:      meter_weight = value[WEIGHT_W-1:0];
         default:         ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_meter(input logic en, input logic [GRAN_W-1:0] gran,
                            input logic [WEIGHT_W-1:0] weight);
      csr_set(CSR_ENABLE, CSR_DATA_W'(en));
      csr_set(CSR_GRANULARITY, CSR_DATA_W'(gran));
      csr_set(CSR_WEIGHT, CSR_DATA_W'(weight));
   endtask

   // ---------------------------------------------------------------------
   // receiver: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : receiver
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!rx_quiet && $urandom_range(99) < 25) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // checker: each rsp beat against the oldest owed reading
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_readings.size() == 0) begin
            $error("rsp beat with no reading owed");
            mismatches++;
         end else begin
            want = owed_readings.pop_front();
            check_field("average_rate", want.average_rate, rsp_data.average_rate);
            check_field("peak_rate", want.peak_rate, rsp_data.peak_rate);
            check_field("packet_count", want.packet_count, rsp_data.packet_count);
            check_field("byte_count", want.byte_count, rsp_data.byte_count);
            check_field("elapsed_us", want.elapsed_us, rsp_data.elapsed_us);
         end
      end
   end

   // watchdog: too long without any beat or write means the block hung
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // enable is low out of reset, so the readings stay at zero
   task automatic test_disabled_after_reset();
      send_packet(32'h0000_0000, 16'h0000);
      send_packet(32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // start mark, timestamp wrap, zero gap, quotient overflow and the
   // granularity boundary, under the reset granularity and weight
   task automatic test_start_and_saturation();
      csr_set(CSR_ENABLE, CSR_DATA_W'(1));
      tx_clock = 32'hFFFF_FFF0;
      send_packet(tx_clock, 16'hFFFF);        // first packet: start only
      send_after(32'd32, 16'hFFFF);           // wraps past zero, seeds average
      send_after(32'd0, 16'h0001);            // zero gap saturates
      send_after(32'd1, 16'hFFFF);            // quotient overflow saturates
      send_after(32'd999999, 16'h1234);       // just below granularity
      send_after(32'd1000000, 16'h0005);      // equal to granularity: no rate
      send_after(32'hFFFF_FFFF, 16'h8000);    // backwards step: huge gap
   endtask

   // weight zero, above one hundred, exactly one hundred, and a re-seed
   task automatic test_weights();
      csr_set(CSR_WEIGHT, CSR_DATA_W'(0));
      send_after(32'd10, 16'd100);            // average must not move
      csr_set(CSR_WEIGHT, CSR_DATA_W'(127));
      send_after(32'd4, 16'd0);               // zero rate takes over fully
      send_after(32'd8, 16'd800);             // zero average gets seeded
      csr_set(CSR_WEIGHT, CSR_DATA_W'(FULL_WEIGHT));
      send_after(32'd2, 16'd3);
   endtask

   // zero granularity blocks every rate, one lets only a zero gap through,
   // and the widest setting
   task automatic test_granularity();
      csr_set(CSR_GRANULARITY, CSR_DATA_W'(0));
      send_after(32'd0, 16'd10);
      send_after(32'd5, 16'd20);
      csr_set(CSR_GRANULARITY, CSR_DATA_W'(1));
      send_after(32'd0, 16'd7);
      send_after(32'd1, 16'd7);
      csr_set(CSR_GRANULARITY, CSR_DATA_W'(GRAN_MAX));
      send_after(32'(GRAN_MAX) - 1, 16'hFFFF);
   endtask

   // packets while disabled leave the state alone, then back to defaults
   task automatic test_disable_midway();
      csr_set(CSR_ENABLE, CSR_DATA_W'(0));
      send_after(32'd3, 16'hAAAA);
      send_packet($urandom, 16'h5555);
      set_meter(1'b1, GRAN_RESET, WEIGHT_RESET);
   endtask

   // mostly well-formed packet streams with gaps under the granularity,
   // the rest gaps at or above it and jumps to random timestamps
   task automatic run_random_phase(input int unsigned count, input logic en,
                                   input logic [GRAN_W-1:0] gran,
                                   input logic [WEIGHT_W-1:0] weight);
      int unsigned g;
      int unsigned r;
      int unsigned s;
      int unsigned step;
      set_meter(en, gran, weight);
      g = gran;
      tx_clock = $urandom;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 75) begin
            if (g == 0) begin
               step = $urandom_range(50);
            end else begin
               s = $urandom_range(9);
               if (s == 0)
                  step = 0;
               else if (s == 1)
                  step = g - 1;
               else if (s < 6)
                  step = $urandom_range((g - 1 < 300) ? g - 1 : 300);
               else
                  step = $urandom_range(g - 1);
            end
            tx_clock = tx_clock + step;
         end else if (r < 88) begin
            tx_clock = tx_clock + g + $urandom_range(2000);
         end else begin
            tx_clock = $urandom;
         end
         send_packet(tx_clock, pick_size());
      end
   endtask

   task automatic test_random_sweep();
      run_random_phase(190, 1'b1, GRAN_RESET, WEIGHT_RESET);
      run_random_phase(190, 1'b1, GRAN_MAX, 7'd0);
      run_random_phase(150, 1'b1, 20'd1, FULL_WEIGHT);
      // a stretch with no idling on either side
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      run_random_phase(150, 1'b1, 20'd64, 7'($urandom_range(127)));
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      run_random_phase(100, 1'b1, 20'd0, 7'd127);
      run_random_phase(30, 1'b0, 20'($urandom_range(GRAN_MAX)), 7'($urandom_range(127)));
      run_random_phase(190, 1'b1, 20'($urandom_range(GRAN_MAX, 1)),
                       7'($urandom_range(127)));
      run_random_phase(190, 1'b1, 20'($urandom_range(5000, 1)), 7'($urandom_range(100)));
   endtask

   // receiver holds off for a long stretch while packets keep coming, so the
   // block fills up and stalls req
   task automatic test_long_hold();
      wait_drain();
      hold_request = 1'b1;
      tx_quiet     = 1'b1;
      repeat (12)
         send_after($urandom_range(500, 1), pick_size());
      tx_quiet = 1'b0;
   endtask

   // sender pauses until every reading is back, then carries on
   task automatic test_drain_pause();
      repeat (15)
         send_after($urandom_range(2000), pick_size());
      wait_drain();
      repeat (15)
         send_after($urandom_range(2000), pick_size());
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ENABLE;
      csr_write_data   = '0;
      hold_request     = 1'b0;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      tx_clock         = '0;
      mismatches       = 0;

      // reset values of registers and state
      meter_on      = 1'b0;
      meter_gran    = GRAN_RESET;
      meter_weight  = WEIGHT_RESET;
      meter_started = 1'b0;
      meter_first   = '0;
      meter_last    = '0;
      meter_avg     = '0;
      meter_peak    = '0;
      meter_packets = '0;
      meter_bytes   = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_disabled_after_reset();
      test_start_and_saturation();
      test_weights();
      test_granularity();
      test_disable_midway();
      test_random_sweep();
      test_long_hold();
      test_drain_pause();

      // all readings in, then let any stray rsp beats show up
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
